[design/usb_control_transfer_td_builder_core_defines.svh]
// ---------------------------------------------------------------------------
// UCTB assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef USB_CONTROL_TRANSFER_TD_BUILDER_CORE_DEFINES_SVH
`define USB_CONTROL_TRANSFER_TD_BUILDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define UCTB_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("uctb assertion failed");
`define UCTB_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("uctb assertion failed");
`else
`define UCTB_ASSERT(name, prop)
`define UCTB_ASSERT_ALWAYS(name, prop)
`endif
`endif

[design/uctb_pkg.sv]
// ---------------------------------------------------------------------------
// uctb_pkg
// Shared types, constants and helpers of the control transfer TD builder.
// ---------------------------------------------------------------------------
package uctb_pkg;

  localparam logic [7:0]  PID_SETUP = 8'h2D;
  localparam logic [7:0]  PID_IN    = 8'h69;
  localparam logic [7:0]  PID_OUT   = 8'hE1;
  localparam logic [10:0] LEN_MASK  = 11'h7FF;
  localparam logic [10:0] SETUP_LEN_M1 = 11'd7;  // 8-byte request, minus one

  typedef struct packed {
    logic [6:0]  device_address;
    logic        low_speed;
    logic [6:0]  max_packet;
    logic        dir_in;
    logic [15:0] data_len;
    logic [31:0] setup_address;
    logic [31:0] data_address;
    logic        too_long;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_DATA,
    BK_STATUS,
    BK_ERROR
  } bk_state_t;

  // error count 3, active, optional low speed
  function automatic logic [31:0] ctrl_word(input logic ls);
    ctrl_word = {3'b000, 2'b11, ls, 2'b00, 1'b1, 23'd0};
  endfunction

  // maxlen | reserved | toggle | endpoint 0 | address | PID
  function automatic logic [31:0] make_token(input logic [10:0] len_m1,
                                             input logic        toggle,
                                             input logic [6:0]  addr,
                                             input logic [7:0]  pid);
    make_token = {len_m1, 1'b0, toggle, 4'd0, addr, pid};
  endfunction

endpackage

[design/uctb_front.sv]
// ---------------------------------------------------------------------------
// uctb_front
// Accepts requests, flags chains that exceed the descriptor limit.
// ---------------------------------------------------------------------------
module uctb_front #(
  parameter int unsigned MAX_TDS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [6:0]          device_address,
  input  logic                low_speed,
  input  logic [6:0]          max_packet,
  input  logic                dir_in,
  input  logic [15:0]         data_len,
  input  logic [31:0]         setup_address,
  input  logic [31:0]         data_address,
  output logic                push_valid,
  input  logic                push_ready,
  output uctb_pkg::req_t      push_data
);
  import uctb_pkg::*;

  localparam int unsigned DATA_MAX = MAX_TDS - 2;

  logic        f_valid;
  req_t        f_item;
  logic [16:0] limit;
  logic        too_long;

  // ceil(len/mp) > N  <=>  len > N*mp ; mp == 0 with data falls out as too long
  assign limit    = 17'(max_packet) * 17'(DATA_MAX);
  assign too_long = {1'b0, data_len} > limit;

  assign in_ready   = !f_valid || push_ready;
  assign push_valid = f_valid;
  assign push_data  = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item.device_address <= device_address;
      f_item.low_speed      <= low_speed;
      f_item.max_packet     <= max_packet;
      f_item.dir_in         <= dir_in;
      f_item.data_len       <= data_len;
      f_item.setup_address  <= setup_address;
      f_item.data_address   <= data_address;
      f_item.too_long       <= too_long;
    end
  end

endmodule

[design/uctb_queue.sv]
// ---------------------------------------------------------------------------
// uctb_queue
// Two-entry request queue between front and back.
// ---------------------------------------------------------------------------
module uctb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  uctb_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output uctb_pkg::req_t pop_data
);
  import uctb_pkg::*;

  req_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

[design/uctb_back.sv]
// ---------------------------------------------------------------------------
// uctb_back
// Descriptor sequencer: SETUP, data, status, one word set per cycle if taken.
// ---------------------------------------------------------------------------
module uctb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  uctb_pkg::req_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [5:0]     td_index,
  output logic [31:0]    control_status,
  output logic [31:0]    token,
  output logic [31:0]    buffer_address,
  output logic           too_long,
  output logic           last
);
  import uctb_pkg::*;

  bk_state_t   state, state_next;
  req_t        job, job_next;
  logic [15:0] remaining, remaining_next;
  logic [31:0] ptr, ptr_next;
  logic        toggle, toggle_next;
  logic [5:0]  idx, idx_next;

  logic        out_valid_next;
  logic [5:0]  td_index_next;
  logic [31:0] control_status_next;
  logic [31:0] token_next;
  logic [31:0] buffer_address_next;
  logic        too_long_next;
  logic        last_next;

  logic        slot_free;
  logic [6:0]  chunk;
  logic [7:0]  data_pid;
  logic [7:0]  stat_pid;

  assign slot_free = !out_valid || out_ready;
  assign chunk     = (remaining > {9'd0, job.max_packet}) ? job.max_packet : remaining[6:0];
  assign data_pid  = job.dir_in ? PID_IN : PID_OUT;
  assign stat_pid  = job.dir_in ? PID_OUT : PID_IN;

  always_comb begin
    state_next          = state;
    job_next            = job;
    remaining_next      = remaining;
    ptr_next            = ptr;
    toggle_next         = toggle;
    idx_next            = idx;
    pop_ready           = 1'b0;
    out_valid_next      = out_valid && !out_ready;
    td_index_next       = td_index;
    control_status_next = control_status;
    token_next          = token;
    buffer_address_next = buffer_address;
    too_long_next       = too_long;
    last_next           = last;

    unique case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          job_next       = pop_data;
          remaining_next = pop_data.data_len;
          ptr_next       = pop_data.data_address;
          toggle_next    = 1'b0;
          idx_next       = 6'd0;
          state_next     = pop_data.too_long ? BK_ERROR : BK_SETUP;
        end
      end
      BK_ERROR: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          td_index_next       = 6'd0;
          control_status_next = 32'd0;
          token_next          = 32'd0;
          buffer_address_next = 32'd0;
          too_long_next       = 1'b1;
          last_next           = 1'b1;
          state_next          = BK_IDLE;
        end
      end
      BK_SETUP: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          td_index_next       = idx;
          control_status_next = ctrl_word(job.low_speed);
          token_next          = make_token(SETUP_LEN_M1, 1'b0, job.device_address, PID_SETUP);
          buffer_address_next = job.setup_address;
          too_long_next       = 1'b0;
          last_next           = 1'b0;
          idx_next            = idx + 6'd1;
          state_next          = (remaining == 16'd0) ? BK_STATUS : BK_DATA;
        end
      end
      BK_DATA: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          td_index_next       = idx;
          control_status_next = ctrl_word(job.low_speed);
          token_next          = make_token({4'd0, chunk} - 11'd1, ~toggle,
                                           job.device_address, data_pid);
          buffer_address_next = ptr;
          too_long_next       = 1'b0;
          last_next           = 1'b0;
          toggle_next         = ~toggle;
          ptr_next            = ptr + 32'(chunk);
          remaining_next      = remaining - 16'(chunk);
          idx_next            = idx + 6'd1;
          if (remaining == 16'(chunk)) state_next = BK_STATUS;
        end
      end
      BK_STATUS: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          td_index_next       = idx;
          control_status_next = ctrl_word(job.low_speed);
          token_next          = make_token(LEN_MASK, 1'b1, job.device_address, stat_pid);
          buffer_address_next = 32'd0;
          too_long_next       = 1'b0;
          last_next           = 1'b1;
          state_next          = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    job            <= job_next;
    remaining      <= remaining_next;
    ptr            <= ptr_next;
    toggle         <= toggle_next;
    idx            <= idx_next;
    td_index       <= td_index_next;
    control_status <= control_status_next;
    token          <= token_next;
    buffer_address <= buffer_address_next;
    too_long       <= too_long_next;
    last           <= last_next;
  end

endmodule

[design/usb_control_transfer_td_builder_core.sv]
// A request of N descriptors (SETUP, ceil(data_len/max_packet) data stage
// descriptors, status) streams out at one descriptor per cycle while the
// output is taken, once the sequencer has fetched the request from its queue
// in its idle state; a request whose chain would exceed MAX_TDS gives a single
// error result. The back-end descriptor sequencer sets this rate; the front
// stage and a two-entry queue take up to three further requests while it works.
// ---------------------------------------------------------------------------
// usb_control_transfer_td_builder_core
// Builds the UHCI transfer descriptor words of a USB control transfer.
// ---------------------------------------------------------------------------
`include "usb_control_transfer_td_builder_core_defines.svh"
module usb_control_transfer_td_builder_core #(
  parameter int unsigned MAX_TDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  device_address,
  input  logic        low_speed,
  input  logic [6:0]  max_packet,
  input  logic        dir_in,
  input  logic [15:0] data_len,
  input  logic [31:0] setup_address,
  input  logic [31:0] data_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  td_index,
  output logic [31:0] control_status,
  output logic [31:0] token,
  output logic [31:0] buffer_address,
  output logic        too_long,
  output logic        last
);
  import uctb_pkg::*;

  logic push_valid;
  logic push_ready;
  req_t push_data;
  logic pop_valid;
  logic pop_ready;
  req_t pop_data;

  uctb_front #(.MAX_TDS(MAX_TDS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .device_address (device_address),
    .low_speed      (low_speed),
    .max_packet     (max_packet),
    .dir_in         (dir_in),
    .data_len       (data_len),
    .setup_address  (setup_address),
    .data_address   (data_address),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  uctb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  uctb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .td_index       (td_index),
    .control_status (control_status),
    .token          (token),
    .buffer_address (buffer_address),
    .too_long       (too_long),
    .last           (last)
  );

  // error result is a lone, final entry at index 0
  `UCTB_ASSERT(a_err_single, out_valid && too_long |-> last && td_index == 6'd0)
  // SETUP always heads the chain
  `UCTB_ASSERT(a_setup_first, out_valid && !too_long && token[7:0] == PID_SETUP |-> td_index == 6'd0)
  // status stage closes the chain with toggle 1 and no buffer
  `UCTB_ASSERT(a_status_form, out_valid && !too_long && last |-> token[19] && buffer_address == 32'd0)

endmodule
